// ===== sv/qrs_pkg.sv =====
// Shared constants, codes and types for the quadratic root solver.
package qrs_pkg;

    localparam int COEF_W        = 32;
    localparam int TOL_W         = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [APB_AW-1:0] REG_TOL_ADDR = 3'd0;

    localparam logic [1:0] CASE_REAL    = 2'd0;
    localparam logic [1:0] CASE_DOUBLE  = 2'd1;
    localparam logic [1:0] CASE_COMPLEX = 2'd2;
    localparam logic [1:0] CASE_AZERO   = 2'd3;

    localparam logic [COEF_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] SAT_NEG = 32'h8000_0000;

    // side data carried along the square root chain
    typedef struct packed {
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] ua;
        logic              aneg;
        logic              azero;
        logic              cnear;
        logic              dnear;
        logic              dneg;
    } qrs_side_t;

    // side data carried along the divider chain
    typedef struct packed {
        logic [2:0] neg;
        logic       azero;
        logic       cnear;
        logic       dnear;
        logic       dneg;
    } qrs_dflags_t;

endpackage

// ===== sv/qrs_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root chain.
module qrs_sqrt_cell #(
    parameter int RW  = 66,
    parameter int RTW = 33,
    parameter int PW  = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           vld_i,
    input  logic [RW-1:0]  rad_i,
    input  logic [RTW+1:0] rem_i,
    input  logic [RTW-1:0] root_i,
    input  logic [PW-1:0]  side_i,
    output logic           vld_o,
    output logic [RW-1:0]  rad_o,
    output logic [RTW+1:0] rem_o,
    output logic [RTW-1:0] root_o,
    output logic [PW-1:0]  side_o
);

    logic           vld_reg;
    logic [RW-1:0]  rad_reg, rad_next;
    logic [RTW+1:0] rem_reg, rem_next;
    logic [RTW-1:0] root_reg, root_next;
    logic [PW-1:0]  side_reg;
    logic [RTW+3:0] remt, trial, diff;
    logic           ge;

    always_comb begin
        remt      = {rem_i, rad_i[RW-1 -: 2]};
        trial     = {2'b00, root_i, 2'b01};
        diff      = remt - trial;
        ge        = remt >= trial;
        rem_next  = ge ? diff[RTW+1:0] : remt[RTW+1:0];
        root_next = {root_i[RTW-2:0], ge};
        rad_next  = {rad_i[RW-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_i;
        end
    end

    assign vld_o  = vld_reg;
    assign rad_o  = rad_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;
    assign side_o = side_reg;

endmodule

// ===== sv/qrs_div_cell.sv =====
// One quotient-bit cell of the pipelined restoring divider, several lanes sharing a divisor.
module qrs_div_cell #(
    parameter int NW = 51,
    parameter int DW = 33,
    parameter int LN = 3,
    parameter int PW = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   vld_i,
    input  logic [DW-1:0]          dv_i,
    input  logic [LN-1:0][DW-1:0]  rem_i,
    input  logic [LN-1:0][NW-1:0]  nq_i,
    input  logic [PW-1:0]          side_i,
    output logic                   vld_o,
    output logic [DW-1:0]          dv_o,
    output logic [LN-1:0][DW-1:0]  rem_o,
    output logic [LN-1:0][NW-1:0]  nq_o,
    output logic [PW-1:0]          side_o
);

    logic                  vld_reg;
    logic [DW-1:0]         dv_reg;
    logic [LN-1:0][DW-1:0] rem_reg, rem_next;
    logic [LN-1:0][NW-1:0] nq_reg, nq_next;
    logic [PW-1:0]         side_reg;
    logic [LN-1:0][DW:0]   remt, diff;
    logic [LN-1:0]         ge;

    always_comb begin
        for (int i = 0; i < LN; i++) begin
            remt[i]     = {rem_i[i], nq_i[i][NW-1]};
            diff[i]     = remt[i] - {1'b0, dv_i};
            ge[i]       = remt[i] >= {1'b0, dv_i};
            rem_next[i] = ge[i] ? diff[i][DW-1:0] : remt[i][DW-1:0];
            nq_next[i]  = {nq_i[i][NW-2:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_reg   <= dv_i;
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
            side_reg <= side_i;
        end
    end

    assign vld_o  = vld_reg;
    assign dv_o   = dv_reg;
    assign rem_o  = rem_reg;
    assign nq_o   = nq_reg;
    assign side_o = side_reg;

endmodule

// ===== sv/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: front stages, root and divider chains, output stage.
// Usage:
//   Input stream s_*: one word per equation, tdata = {c, b, a}, signed fixed point with
//   FRAC_BITS fraction bits. Output stream m_*: one word per input word, in order,
//   tdata = {root2_imag, root2_real, root1_imag, root1_real}, tuser = {saturated, root_case}.
//   APB register 0 (zero_tolerance, 16 bits) sets the near-zero bound for c and for
//   the discriminant; write it only while no words are in flight.
// Pipeline:
//   Four front stages, 33 square root cells (one root bit each), one numerator stage,
//   35 + FRAC_BITS divider cells (one quotient bit each) and the output register.
//   Throughput is one word per cycle while backpressure does not hold the chain;
//   each cell passes its word on every cycle in which the chain advances.
// Reset:
//   aresetn low clears all valid flags and the tolerance register; m_tvalid drops.
// Backpressure:
//   The whole chain advances only while the output register is empty or being taken;
//   with m_tready low and a word waiting, s_tready is low and every stage holds.
module quadratic_root_solver #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [95:0]                s_tdata,   // coef_a, coef_b, coef_c
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [127:0]               m_tdata,   // root1_real, root1_imag, root2_real, root2_imag
    output logic [2:0]                 m_tuser,   // root_case[1:0], saturated
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qrs_pkg::APB_AW-1:0] paddr,
    input  logic [qrs_pkg::APB_DW-1:0] pwdata,
    output logic [qrs_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    localparam int CW   = qrs_pkg::COEF_W;
    localparam int TW   = qrs_pkg::TOL_W;
    localparam int RW   = 2 * CW + 2;
    localparam int RTW  = RW / 2;
    localparam int MW   = RTW + 1;
    localparam int SNW  = MW + 1;
    localparam int NW   = MW + FRAC_BITS + 1;
    localparam int DW   = CW + 1;
    localparam int SPW  = $bits(qrs_pkg::qrs_side_t);
    localparam int DPW  = $bits(qrs_pkg::qrs_dflags_t);
    localparam int LN   = 3;

    logic en;
    logic [TW-1:0] tol_reg;

    // configuration
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (psel && penable && pwrite && paddr == qrs_pkg::REG_TOL_ADDR) begin
            tol_reg <= pwdata[TW-1:0];
        end
    end
    assign prdata = (paddr == qrs_pkg::REG_TOL_ADDR) ?
                    {{(qrs_pkg::APB_DW-TW){1'b0}}, tol_reg} : '0;

    logic out_vld_reg;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // stage 1: magnitudes, a-zero and c checks
    logic signed [CW-1:0] in_a, in_b, in_c;
    assign in_a = s_tdata[CW-1:0];
    assign in_b = s_tdata[2*CW-1:CW];
    assign in_c = s_tdata[3*CW-1:2*CW];

    logic                 s1_vld_reg;
    logic signed [CW-1:0] s1_b_reg;
    logic [CW-1:0]        s1_ua_reg, s1_ub_reg, s1_uc_reg;
    logic                 s1_aneg_reg, s1_cneg_reg, s1_azero_reg, s1_cnear_reg;
    logic [CW-1:0]        ua_next, ub_next, uc_next;

    always_comb begin
        ua_next = in_a[CW-1] ? -in_a : in_a;
        ub_next = in_b[CW-1] ? -in_b : in_b;
        uc_next = in_c[CW-1] ? -in_c : in_c;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_b_reg     <= in_b;
            s1_ua_reg    <= ua_next;
            s1_ub_reg    <= ub_next;
            s1_uc_reg    <= uc_next;
            s1_aneg_reg  <= in_a[CW-1];
            s1_cneg_reg  <= in_c[CW-1];
            s1_azero_reg <= (in_a == '0);
            s1_cnear_reg <= (uc_next <= {{(CW-TW){1'b0}}, tol_reg});
        end
    end

    // stage 2: products
    logic                 s2_vld_reg;
    logic signed [CW-1:0] s2_b_reg;
    logic [CW-1:0]        s2_ua_reg;
    logic [2*CW-1:0]      s2_sq_reg, s2_p_reg;
    logic                 s2_aneg_reg, s2_same_reg, s2_azero_reg, s2_cnear_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_b_reg     <= s1_b_reg;
            s2_ua_reg    <= s1_ua_reg;
            s2_sq_reg    <= s1_ub_reg * s1_ub_reg;
            s2_p_reg     <= s1_ua_reg * s1_uc_reg;
            s2_aneg_reg  <= s1_aneg_reg;
            s2_same_reg  <= (s1_aneg_reg == s1_cneg_reg);
            s2_azero_reg <= s1_azero_reg;
            s2_cnear_reg <= s1_cnear_reg;
        end
    end

    // stage 3: discriminant
    logic                 s3_vld_reg;
    logic signed [CW-1:0] s3_b_reg;
    logic [CW-1:0]        s3_ua_reg;
    logic [RW-1:0]        s3_d_reg, d_next;
    logic                 s3_aneg_reg, s3_azero_reg, s3_cnear_reg;

    always_comb begin
        if (s2_same_reg) begin
            d_next = {2'b00, s2_sq_reg} - {s2_p_reg, 2'b00};
        end else begin
            d_next = {2'b00, s2_sq_reg} + {s2_p_reg, 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_b_reg     <= s2_b_reg;
            s3_ua_reg    <= s2_ua_reg;
            s3_d_reg     <= d_next;
            s3_aneg_reg  <= s2_aneg_reg;
            s3_azero_reg <= s2_azero_reg;
            s3_cnear_reg <= s2_cnear_reg;
        end
    end

    // stage 4: magnitude of D and its near-zero check
    logic                  s4_vld_reg;
    logic [RW-1:0]         s4_dmag_reg;
    qrs_pkg::qrs_side_t    s4_side_reg, side_next;
    logic signed [RW-1:0]  tolw;

    assign tolw = signed'(RW'(tol_reg) << FRAC_BITS);

    always_comb begin
        side_next       = '0;
        side_next.b     = s3_b_reg;
        side_next.ua    = s3_ua_reg;
        side_next.aneg  = s3_aneg_reg;
        side_next.azero = s3_azero_reg;
        side_next.cnear = s3_cnear_reg;
        side_next.dneg  = s3_d_reg[RW-1];
        side_next.dnear = ($signed(s3_d_reg) <= tolw) && ($signed(s3_d_reg) >= -tolw);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_dmag_reg <= s3_d_reg[RW-1] ? -s3_d_reg : s3_d_reg;
            s4_side_reg <= side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_tvalid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // square root chain
    logic [RTW:0]           sq_vld;
    logic [RTW:0][RW-1:0]   sq_rad;
    logic [RTW:0][RTW+1:0]  sq_rem;
    logic [RTW:0][RTW-1:0]  sq_root;
    logic [RTW:0][SPW-1:0]  sq_side;

    assign sq_vld[0]  = s4_vld_reg;
    assign sq_rad[0]  = s4_dmag_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = s4_side_reg;

    for (genvar k = 0; k < RTW; k++) begin : g_sqrt
        qrs_sqrt_cell #(.RW(RW), .RTW(RTW), .PW(SPW)) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .en     (en),
            .vld_i  (sq_vld[k]),
            .rad_i  (sq_rad[k]),
            .rem_i  (sq_rem[k]),
            .root_i (sq_root[k]),
            .side_i (sq_side[k]),
            .vld_o  (sq_vld[k+1]),
            .rad_o  (sq_rad[k+1]),
            .rem_o  (sq_rem[k+1]),
            .root_o (sq_root[k+1]),
            .side_o (sq_side[k+1])
        );
    end

    // stage 5: numerators and divisor
    qrs_pkg::qrs_side_t    sd;
    logic signed [SNW-1:0] nb, sx;
    logic [LN-1:0][SNW-1:0] num;
    logic [LN-1:0][MW-1:0]  nmag;
    logic [DW-1:0]          den;
    logic                   special;

    logic                    s5_vld_reg;
    logic [DW-1:0]           s5_den_reg;
    logic [LN-1:0][NW-1:0]   s5_n_reg;
    qrs_pkg::qrs_dflags_t    s5_fl_reg, fl_next;

    always_comb begin
        sd      = sq_side[RTW];
        nb      = -SNW'(signed'(sd.b));
        sx      = signed'({2'b00, sq_root[RTW]});
        special = sd.cnear || sd.dnear || sd.dneg;
        num[0]  = special ? nb : nb + sx;
        num[1]  = nb - sx;
        num[2]  = sx;
        den     = sd.cnear ? {1'b0, sd.ua} : {sd.ua, 1'b0};
        fl_next       = '0;
        fl_next.azero = sd.azero;
        fl_next.cnear = sd.cnear;
        fl_next.dnear = sd.dnear;
        fl_next.dneg  = sd.dneg;
        for (int i = 0; i < LN; i++) begin
            nmag[i]        = num[i][SNW-1] ? MW'(-num[i]) : num[i][MW-1:0];
            fl_next.neg[i] = num[i][SNW-1] ^ sd.aneg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_den_reg <= den;
            s5_fl_reg  <= fl_next;
            for (int i = 0; i < LN; i++) begin
                s5_n_reg[i] <= (NW'(nmag[i]) << FRAC_BITS) + NW'(den >> 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_vld_reg <= 1'b0;
        end else if (en) begin
            s5_vld_reg <= sq_vld[RTW];
        end
    end

    // divider chain
    logic [NW:0]                     dv_vld;
    logic [NW:0][DW-1:0]             dv_div;
    logic [NW:0][LN-1:0][DW-1:0]     dv_rem;
    logic [NW:0][LN-1:0][NW-1:0]     dv_nq;
    logic [NW:0][DPW-1:0]            dv_side;

    assign dv_vld[0]  = s5_vld_reg;
    assign dv_div[0]  = s5_den_reg;
    assign dv_rem[0]  = '0;
    assign dv_nq[0]   = s5_n_reg;
    assign dv_side[0] = s5_fl_reg;

    for (genvar k = 0; k < NW; k++) begin : g_div
        qrs_div_cell #(.NW(NW), .DW(DW), .LN(LN), .PW(DPW)) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .en     (en),
            .vld_i  (dv_vld[k]),
            .dv_i   (dv_div[k]),
            .rem_i  (dv_rem[k]),
            .nq_i   (dv_nq[k]),
            .side_i (dv_side[k]),
            .vld_o  (dv_vld[k+1]),
            .dv_o   (dv_div[k+1]),
            .rem_o  (dv_rem[k+1]),
            .nq_o   (dv_nq[k+1]),
            .side_o (dv_side[k+1])
        );
    end

    // output stage: sign, saturation, case select
    function automatic logic [CW:0] sat_q(input logic [NW-1:0] q, input logic neg);
        logic          flag;
        logic [CW-1:0] val;
        if (neg) begin
            flag = (|q[NW-1:CW]) || (q[CW-1] && (|q[CW-2:0]));
            val  = flag ? qrs_pkg::SAT_NEG : -q[CW-1:0];
        end else begin
            flag = |q[NW-1:CW-1];
            val  = flag ? qrs_pkg::SAT_POS : q[CW-1:0];
        end
        return {flag, val};
    endfunction

    qrs_pkg::qrs_dflags_t fo;
    logic [CW:0]   l0, l1, l2p, l2n;
    logic [CW-1:0] r1r, r1i, r2r, r2i;
    logic [1:0]    kase;
    logic          sat;

    logic [CW-1:0] r1r_reg, r1i_reg, r2r_reg, r2i_reg;
    logic [1:0]    kase_reg;
    logic          sat_reg;

    always_comb begin
        fo   = dv_side[NW];
        l0   = sat_q(dv_nq[NW][0], fo.neg[0]);
        l1   = sat_q(dv_nq[NW][1], fo.neg[1]);
        l2p  = sat_q(dv_nq[NW][2], fo.neg[2]);
        l2n  = sat_q(dv_nq[NW][2], !fo.neg[2]);
        r1r  = '0;
        r1i  = '0;
        r2r  = '0;
        r2i  = '0;
        sat  = 1'b0;
        kase = qrs_pkg::CASE_REAL;
        priority if (fo.azero) begin
            kase = qrs_pkg::CASE_AZERO;
        end else if (fo.cnear) begin
            r1r  = l0[CW-1:0];
            sat  = l0[CW];
        end else if (fo.dnear) begin
            kase = qrs_pkg::CASE_DOUBLE;
            r1r  = l0[CW-1:0];
            r2r  = l0[CW-1:0];
            sat  = l0[CW];
        end else if (fo.dneg) begin
            kase = qrs_pkg::CASE_COMPLEX;
            r1r  = l0[CW-1:0];
            r2r  = l0[CW-1:0];
            r1i  = l2p[CW-1:0];
            r2i  = l2n[CW-1:0];
            sat  = l0[CW] || l2p[CW] || l2n[CW];
        end else begin
            r1r  = l0[CW-1:0];
            r2r  = l1[CW-1:0];
            sat  = l0[CW] || l1[CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1r_reg  <= r1r;
            r1i_reg  <= r1i;
            r2r_reg  <= r2r;
            r2i_reg  <= r2i;
            kase_reg <= kase;
            sat_reg  <= sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= dv_vld[NW];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {r2i_reg, r2r_reg, r1i_reg, r1r_reg};
    assign m_tuser  = {sat_reg, kase_reg};

    // checks
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_azero_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == qrs_pkg::CASE_AZERO) |-> (m_tdata == '0 && !m_tuser[2]))
        else $error("a-zero case with nonzero roots");

    a_double_eq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == qrs_pkg::CASE_DOUBLE) |->
        (m_tdata[31:0] == m_tdata[95:64] && m_tdata[63:32] == '0 && m_tdata[127:96] == '0))
        else $error("double root mismatch");

    a_conj: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == qrs_pkg::CASE_COMPLEX && !m_tuser[2]) |->
        (m_tdata[127:96] == -m_tdata[63:32] && m_tdata[31:0] == m_tdata[95:64]))
        else $error("complex pair not conjugate");

endmodule
